[sv/mspd_pkg.sv]
// package for the multichannel sample packet deframer
// holds the result beat type and the packet layout constants; no dependencies
`default_nettype none

package mspd_pkg;

	// packet layout
	localparam int unsigned SEQ_END  = 4;   // sequence number occupies bytes 0..3
	localparam int unsigned HDR_END  = 12;  // base timestamp occupies bytes 4..11
	localparam int unsigned REC_LEN  = 10;  // delay plus four samples
	localparam int unsigned HDR_BASE = 10;  // fixed part of the expected length

	// byte offsets within a record
	localparam logic [3:0] OFF_DLY_HI   = 4'd0;
	localparam logic [3:0] OFF_DLY_LO   = 4'd1;
	localparam logic [3:0] OFF_SAMPLE_0 = 4'd2;
	localparam logic [3:0] OFF_LAST     = 4'd9;

	// register addresses (word index)
	localparam logic REG_CHANNEL_SELECT = 1'b0;

	// one result beat
	typedef struct packed {
		logic        is_summary;
		logic [15:0] sample_value;
		logic [63:0] sample_time;
		logic [9:0]  sample_index;
		logic [31:0] packet_sequence;
		logic        length_ok;
		logic        last;
	} result_beat_t;

endpackage

`default_nettype wire

[sv/multichannel_sample_packet_deframer_unit.sv]
// top level of the multichannel sample packet deframer
// parses packet bytes, emits selected-channel samples and an end-of-packet summary
// depends on mspd_pkg
//
//  port group   dir   handshake            payload
//  in           in    in_valid/in_ready    data_byte, end_of_packet
//  out          out   out_valid/out_ready  is_summary .. last (one result per beat)
//  apb          in    psel/penable/pready  paddr, pwdata, prdata
//
// one byte per cycle: a byte is taken into an input register, parsed there against the
// packet state and its results pushed into a four-entry result queue.
// a byte that yields two results (last sample and summary) holds the queue two beats.
// the input register parses only while the queue has room for two results, so a
// stalled output backs up into in_ready once three result beats are waiting.
// arst_n clears the packet state, the queue and channel_select.
`default_nettype none

module multichannel_sample_packet_deframer_unit #(
	parameter int unsigned SAMPLES = 145
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_packet,
	// result output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_summary,
	output logic [15:0]      sample_value,
	output logic [63:0]      sample_time,
	output logic [9:0]       sample_index,
	output logic [31:0]      packet_sequence,
	output logic             length_ok,
	output logic             last,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic [15:0] EXP_LEN = 16'(mspd_pkg::REC_LEN * SAMPLES + mspd_pkg::HDR_BASE);
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// configuration register
	logic [1:0] channel_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= 2'd0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == mspd_pkg::REG_CHANNEL_SELECT) begin
			channel_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == mspd_pkg::REG_CHANNEL_SELECT) begin
			prdata = {30'd0, channel_q};
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eop_s1;
	logic       go;
	logic [2:0] cnt_q;

	assign go       = valid_s1 && (cnt_q <= 3'd2);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eop_s1  <= end_of_packet;
		end
	end

	// packet state
	logic [15:0] pos_q;
	logic [31:0] seq_q;
	logic [63:0] base_q;
	logic [15:0] delay_q;
	logic [7:0]  hi_q;
	logic [9:0]  rec_q;
	logic [3:0]  off_q;

	logic [15:0] pos_n;
	logic [31:0] seq_n;
	logic [63:0] base_n;
	logic [15:0] delay_n;
	logic [7:0]  hi_n;
	logic [9:0]  rec_n;
	logic [3:0]  off_n;
	logic        emit;
	logic [3:0]  samp_off;
	logic [63:0] stamp;
	mspd_pkg::result_beat_t samp_res;
	mspd_pkg::result_beat_t summ_res;

	// parse one byte
	always_comb begin
		pos_n    = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;
		seq_n    = seq_q;
		base_n   = base_q;
		delay_n  = delay_q;
		hi_n     = hi_q;
		rec_n    = rec_q;
		off_n    = off_q;
		emit     = 1'b0;
		samp_off = off_q - mspd_pkg::OFF_SAMPLE_0;
		stamp    = base_q + ((rec_q != 10'd0) ? {48'd0, delay_q} : 64'd0);

		if (pos_q < EXP_LEN) begin
			if (pos_q < 16'(mspd_pkg::SEQ_END)) begin
				seq_n = {seq_q[23:0], byte_s1};
			end else if (pos_q < 16'(mspd_pkg::HDR_END)) begin
				base_n = {base_q[55:0], byte_s1};
				if (pos_q == 16'(mspd_pkg::HDR_END - 1)) begin
					off_n = mspd_pkg::OFF_SAMPLE_0;
				end
			end else begin
				// record body
				if (off_q == mspd_pkg::OFF_DLY_HI) begin
					delay_n = {byte_s1, 8'd0};
				end else if (off_q == mspd_pkg::OFF_DLY_LO) begin
					delay_n = {delay_q[15:8], byte_s1};
				end else if (!off_q[0]) begin
					hi_n = byte_s1;
				end else begin
					emit = (samp_off[2:1] == channel_q);
				end
				if (off_q == mspd_pkg::OFF_LAST) begin
					off_n = mspd_pkg::OFF_DLY_HI;
					rec_n = rec_q + 10'd1;
				end else begin
					off_n = off_q + 4'd1;
				end
			end
		end

		samp_res.is_summary      = 1'b0;
		samp_res.sample_value    = {hi_q, byte_s1};
		samp_res.sample_time     = stamp;
		samp_res.sample_index    = rec_q;
		samp_res.packet_sequence = 32'd0;
		samp_res.length_ok       = 1'b0;
		samp_res.last            = !eop_s1;

		summ_res.is_summary      = 1'b1;
		summ_res.sample_value    = 16'd0;
		summ_res.sample_time     = 64'd0;
		summ_res.sample_index    = 10'd0;
		summ_res.packet_sequence = seq_n;
		summ_res.length_ok       = (pos_n == EXP_LEN);
		summ_res.last            = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 16'd0;
			seq_q   <= 32'd0;
			base_q  <= 64'd0;
			delay_q <= 16'd0;
			hi_q    <= 8'd0;
			rec_q   <= 10'd0;
			off_q   <= 4'd0;
		end else if (go) begin
			if (eop_s1) begin
				pos_q   <= 16'd0;
				seq_q   <= 32'd0;
				base_q  <= 64'd0;
				delay_q <= 16'd0;
				hi_q    <= 8'd0;
				rec_q   <= 10'd0;
				off_q   <= 4'd0;
			end else begin
				pos_q   <= pos_n;
				seq_q   <= seq_n;
				base_q  <= base_n;
				delay_q <= delay_n;
				hi_q    <= hi_n;
				rec_q   <= rec_n;
				off_q   <= off_n;
			end
		end
	end

	// result queue
	mspd_pkg::result_beat_t fifo_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [1:0] push_n;
	logic       pop;

	assign push_n = go ? ({1'b0, emit} + {1'b0, eop_s1}) : 2'd0;
	assign pop    = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_q] <= emit ? samp_res : summ_res;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_q + 2'd1] <= summ_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'd0, pop};
		end
	end

	// output beat
	assign out_valid       = (cnt_q != 3'd0);
	assign is_summary      = fifo_q[rd_q].is_summary;
	assign sample_value    = fifo_q[rd_q].sample_value;
	assign sample_time     = fifo_q[rd_q].sample_time;
	assign sample_index    = fifo_q[rd_q].sample_index;
	assign packet_sequence = fifo_q[rd_q].packet_sequence;
	assign length_ok       = fifo_q[rd_q].length_ok;
	assign last            = fifo_q[rd_q].last;

endmodule

`default_nettype wire

[tb/sv/mspd_result_monitor.sv]
`timescale 1ns / 1ps
// result monitor for the multichannel sample packet deframer
// watches the byte, result and register ports, works out the expected result beats
// and compares them field by field; depends on mspd_pkg

module mspd_result_monitor #(
	parameter int unsigned SAMPLES = 145
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	// result channel
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        is_summary,
	input  logic [15:0] sample_value,
	input  logic [63:0] sample_time,
	input  logic [9:0]  sample_index,
	input  logic [31:0] packet_sequence,
	input  logic        length_ok,
	input  logic        last,
	// register writes
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	// status for the stimulus side
	output int unsigned pending,
	output int unsigned errors
);

	localparam int unsigned FULL_LEN = mspd_pkg::REC_LEN * SAMPLES + mspd_pkg::HDR_BASE;
	localparam int unsigned REC0_END = mspd_pkg::HDR_END + 8;   // record zero has no delay field

	// packet state as the deframer should hold it
	logic [15:0] pkt_pos;
	logic [31:0] seq_acc;
	logic [63:0] base_ts;
	logic [15:0] rec_delay;
	logic [15:0] smp_acc;
	logic [9:0]  rec_idx;
	logic [1:0]  chan_sel;

	mspd_pkg::result_beat_t awaited_results[$];

	task automatic clear_packet();
		pkt_pos = '0;
		seq_acc = '0;
		base_ts = '0;
		rec_delay = '0;
		smp_acc = '0;
		rec_idx = '0;
	endtask

	// advance the packet state by one byte and queue the beats it must produce
	task automatic deframe_byte(input logic [7:0] b, input logic eop);
		int unsigned pos;
		int unsigned ofs;
		int unsigned rel;
		logic        smp_byte;
		mspd_pkg::result_beat_t res;
		pos = pkt_pos;
		ofs = 0;
		smp_byte = 1'b0;
		res = '0;
		if (pos < FULL_LEN) begin
			if (pos < mspd_pkg::SEQ_END) begin
				seq_acc = {seq_acc[23:0], b};
			end else if (pos < mspd_pkg::HDR_END) begin
				base_ts = {base_ts[55:0], b};
			end else if (pos < REC0_END) begin
				rec_idx = '0;
				ofs = pos - mspd_pkg::HDR_END;
				smp_byte = 1'b1;
			end else begin
				rel = pos - REC0_END;
				rec_idx = 10'(1 + rel / mspd_pkg::REC_LEN);
				ofs = rel % mspd_pkg::REC_LEN;
				if (ofs == mspd_pkg::OFF_DLY_HI) begin
					rec_delay = {b, 8'h00};
				end else if (ofs == mspd_pkg::OFF_DLY_LO) begin
					rec_delay[7:0] = b;
				end else begin
					ofs = ofs - mspd_pkg::OFF_SAMPLE_0;
					smp_byte = 1'b1;
				end
			end
		end
		// high byte is always captured, the low byte completes the sample
		if (smp_byte) begin
			if (!ofs[0]) begin
				smp_acc = {b, 8'h00};
			end else begin
				smp_acc[7:0] = b;
				if (ofs[2:1] == chan_sel) begin
					res.sample_value = smp_acc;
					res.sample_time = (rec_idx == '0) ? base_ts : base_ts + 64'(rec_delay);
					res.sample_index = rec_idx;
					res.last = !eop;
					awaited_results.push_back(res);
				end
			end
		end
		if (pkt_pos != 16'hFFFF) begin
			pkt_pos = pkt_pos + 16'd1;
		end
		// summary closes the packet
		if (eop) begin
			res = '0;
			res.is_summary = 1'b1;
			res.packet_sequence = seq_acc;
			res.length_ok = (pkt_pos == FULL_LEN);
			res.last = 1'b1;
			awaited_results.push_back(res);
			clear_packet();
		end
	endtask

	task automatic check_field(input string fname, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10) begin
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, fname, want, got);
			end
		end
	endtask

	// byte and result beats are taken at the rising edge
	always @(posedge clk or negedge arst_n) begin
		mspd_pkg::result_beat_t seen;
		mspd_pkg::result_beat_t want;
		if (!arst_n) begin
			chan_sel = '0;
			clear_packet();
			awaited_results.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr[2] == mspd_pkg::REG_CHANNEL_SELECT) begin
				chan_sel = pwdata[1:0];
			end
			if (in_valid && in_ready) begin
				deframe_byte(data_byte, end_of_packet);
			end
			if (out_valid && out_ready) begin
				seen = {is_summary, sample_value, sample_time, sample_index, packet_sequence,
					length_ok, last};
				if (awaited_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result beat with none expected, summary %b value %h",
							$realtime, seen.is_summary, seen.sample_value);
					end
				end else begin
					want = awaited_results.pop_front();
					check_field("is_summary", 64'(want.is_summary), 64'(seen.is_summary));
					check_field("sample_value", 64'(want.sample_value), 64'(seen.sample_value));
					check_field("sample_time", want.sample_time, seen.sample_time);
					check_field("sample_index", 64'(want.sample_index), 64'(seen.sample_index));
					check_field("packet_sequence", 64'(want.packet_sequence),
						64'(seen.packet_sequence));
					check_field("length_ok", 64'(want.length_ok), 64'(seen.length_ok));
					check_field("last", 64'(want.last), 64'(seen.last));
				end
			end
			pending = awaited_results.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// top of the deframer testbench: clock, reset, byte and register stimulus, result
// back-pressure and the verdict; depends on mspd_pkg and mspd_result_monitor

module testbench;

	// full record count; one full-length packet takes most of the byte budget
	localparam int unsigned NUM_SAMPLES = 145;
	localparam int unsigned FULL_LEN    = mspd_pkg::REC_LEN * NUM_SAMPLES + mspd_pkg::HDR_BASE;
	localparam int unsigned PHASE_BYTES = 70;
	localparam int unsigned SHORT_MAX   = 60;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE      = 16;   // cycles for the pipeline to empty

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        end_of_packet;
	logic        out_valid;
	logic        out_ready;
	logic        is_summary;
	logic [15:0] sample_value;
	logic [63:0] sample_time;
	logic [9:0]  sample_index;
	logic [31:0] packet_sequence;
	logic        length_ok;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned pending;
	int unsigned errors;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_req = 0;

	always #5 clk = ~clk;

	multichannel_sample_packet_deframer_unit #(
		.SAMPLES(NUM_SAMPLES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_packet(end_of_packet),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_summary(is_summary),
		.sample_value(sample_value),
		.sample_time(sample_time),
		.sample_index(sample_index),
		.packet_sequence(packet_sequence),
		.length_ok(length_ok),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	mspd_result_monitor #(
		.SAMPLES(NUM_SAMPLES)
	) result_mon (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_packet(end_of_packet),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_summary(is_summary),
		.sample_value(sample_value),
		.sample_time(sample_time),
		.sample_index(sample_index),
		.packet_sequence(packet_sequence),
		.length_ok(length_ok),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.pending(pending),
		.errors(errors)
	);

	// result back-pressure, with a long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned hold_seen;
		out_ready = 1'b0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// offer one byte beat, with a random gap first; returns at a falling edge
	task automatic put_byte(input logic [7:0] b, input logic eop);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			end_of_packet <= 1'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_packet <= eop;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and let every outstanding result beat arrive
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// register write: setup cycle, then access cycle
	task automatic set_channel(input logic [1:0] chan);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {mspd_pkg::REG_CHANNEL_SELECT, 2'b00};
		pwdata <= {30'($urandom), chan};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// packet of random bytes, end marked on the last one
	task automatic send_bytes(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			put_byte(8'($urandom), i == len - 1);
		end
	endtask

	// one random short packet: cut in the header or somewhere in the first records
	task automatic send_packet(output int unsigned nbytes);
		int unsigned len;
		len = $urandom_range(1, SHORT_MAX);
		send_bytes(len);
		nbytes = len;
	endtask

	initial begin
		logic [95:0] hdr_bytes;
		logic [79:0] rec_bytes;
		int unsigned sent;
		int unsigned len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		end_of_packet = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		set_channel(2'd0);

		// one-byte packet: summary only, length check fails
		put_byte(8'hFF, 1'b1);

		// header extremes, base close to wrap, channel switched between sample bytes
		hdr_bytes = 96'h00FF5AA5_FFFFFFFF_FFFFFFF0;
		for (int i = 0; i < 12; i++) begin
			put_byte(hdr_bytes[95 - 8 * i -: 8], 1'b0);
		end
		put_byte(8'h80, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'h7F, 1'b0);
		set_channel(2'd1);
		put_byte(8'hFE, 1'b0);
		// rest of record zero, then record one with the largest delay, short packet
		rec_bytes = 80'h0000_FFFF_FFFF_1234_ABCD;
		for (int i = 0; i < 10; i++) begin
			put_byte(rec_bytes[79 - 8 * i -: 8], i == 9);
		end

		// full-length packet, then random short packets, under four idling patterns
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct <= 0;
					set_channel(2'd3);
				end
				1: begin
					send_idle_pct = 82;
					stall_pct <= 0;
					set_channel(2'd2);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct <= 82;
					set_channel(2'd0);
				end
				default: begin
					send_idle_pct = 32;
					stall_pct <= 32;
					set_channel(2'd1);
				end
			endcase
			sent = 0;
			if (ph == 0) begin
				// long output hold-off while the full-length packet keeps coming
				hold_req <= hold_req + 1;
				send_bytes(FULL_LEN);
				// sender waits for the block to empty
				drain();
			end else begin
				while (sent < PHASE_BYTES) begin
					send_packet(len);
					sent += len;
				end
			end
		end

		drain();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
